// File: rtl/core/fsrl_pkg.sv
package fsrl_pkg;

    typedef enum logic [2:0] {
        OP_LOAD_PIXEL    = 3'd0,
        OP_LOAD_LANDMARK = 3'd1,
        OP_LOAD_FEATURE  = 3'd2,
        OP_LOAD_BIN      = 3'd3,
        OP_SET_XFORM     = 3'd4,
        OP_PREDICT       = 3'd5
    } t_op;

    localparam logic [1:0] CFG_COLS      = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_FERNS     = 2'd2;
    localparam logic [1:0] CFG_LANDMARKS = 2'd3;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    // datapath commands from the controller
    typedef struct packed {
        logic capture;    // latch the input item
        logic load;       // write a store from the latched item
        logic prj_start;  // clear the bin, fern 0, first point
        logic prj_step;   // run one projection stage step
        logic emit_start; // clear the landmark counter
        logic emit_next;  // advance the landmark counter
    } t_cmd;

    typedef struct packed {
        logic prj_done;   // all fern tests finished
        logic emit_last;  // current landmark is the final one
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// File: rtl/core/fsrl_ram.sv
module fsrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/fsrl_ctrl.sv
module fsrl_ctrl import fsrl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_op     i_op,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_PROJ, S_READ, S_WAIT, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_op == OP_PREDICT) n_state = S_PROJ;
                    else n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            S_PROJ: begin
                o_cmd.prj_step = 1'b1;
                if (i_status.prj_done) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_READ;
                end
            end
            // bin memory read latency
            S_READ: n_state = S_WAIT;
            S_WAIT: begin
                n_out_valid = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (i_status.emit_last) begin
                        n_out_valid = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_out_valid     = 1'b0;
                        n_state         = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE && i_in_valid && i_op == OP_PREDICT) o_cmd.prj_start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// File: rtl/core/fsrl_dpath.sv
module fsrl_dpath import fsrl_pkg::*; #(
    parameter int MAX_FERN_BITS = 5,
    parameter int MAX_LANDMARKS = 29,
    parameter int IMAGE_WIDTH   = 256,
    parameter int IMAGE_HEIGHT  = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data,
    input  t_op                i_op,
    input  logic [15:0]        i_slot,
    input  logic signed [31:0] i_coord_a,
    input  logic signed [31:0] i_coord_b,
    input  logic signed [31:0] i_coord_c,
    input  logic signed [31:0] i_coord_d,
    input  logic signed [31:0] i_aux_value,
    input  logic [4:0]         i_near_a,
    input  logic [4:0]         i_near_b,
    input  logic [15:0]        i_box_width,
    input  logic [15:0]        i_box_height,
    output t_status            o_status,
    output logic [4:0]         o_landmark_index,
    output logic signed [31:0] o_delta_x,
    output logic signed [31:0] o_delta_y,
    output logic [4:0]         o_bin_index,
    output logic               o_last
);
    localparam int PIX_DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int PAW = $clog2(PIX_DEPTH);
    localparam int BIN_DEPTH = (1 << MAX_FERN_BITS) * MAX_LANDMARKS;
    localparam int BAW = $clog2(BIN_DEPTH);
    localparam int LW = $clog2(MAX_LANDMARKS + 1);
    localparam int LIW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int FW = $clog2(MAX_FERN_BITS + 1);
    localparam int FIW = (MAX_FERN_BITS > 1) ? $clog2(MAX_FERN_BITS) : 1;
    localparam int CW = $clog2(IMAGE_WIDTH + 1);
    localparam int RW = $clog2(IMAGE_HEIGHT + 1);

    // latched item
    t_op                r_op;
    logic [15:0]        r_slot;
    logic signed [31:0] r_a, r_b, r_c, r_d, r_aux;
    logic [4:0]         r_na, r_nb;
    logic [15:0]        r_bw, r_bh;

    // configuration
    logic [8:0] r_cols_raw, r_rows_raw;
    logic [2:0] r_ferns_raw;
    logic [4:0] r_lms_raw;

    // transform
    logic signed [31:0] r_rot [4];
    logic signed [31:0] r_scale;
    logic [15:0]        r_box [2];

    // small stores, one flop row per entry
    logic signed [31:0] r_lx [MAX_LANDMARKS];
    logic signed [31:0] r_ly [MAX_LANDMARKS];
    logic signed [31:0] r_o1x [MAX_FERN_BITS], r_o1y [MAX_FERN_BITS];
    logic signed [31:0] r_o2x [MAX_FERN_BITS], r_o2y [MAX_FERN_BITS];
    logic signed [31:0] r_thr [MAX_FERN_BITS];
    logic [4:0]         r_an1 [MAX_FERN_BITS], r_an2 [MAX_FERN_BITS];

    // clamped configuration
    logic [CW-1:0] w_cols;
    logic [RW-1:0] w_rows;
    logic [FW-1:0] w_ferns;
    logic [LW-1:0] w_lms;

    always_comb begin
        if (r_cols_raw == 9'd0) w_cols = CW'(1);
        else if (32'(r_cols_raw) > IMAGE_WIDTH) w_cols = CW'(IMAGE_WIDTH);
        else w_cols = CW'(r_cols_raw);
        if (r_rows_raw == 9'd0) w_rows = RW'(1);
        else if (32'(r_rows_raw) > IMAGE_HEIGHT) w_rows = RW'(IMAGE_HEIGHT);
        else w_rows = RW'(r_rows_raw);
        if (r_ferns_raw == 3'd0) w_ferns = FW'(1);
        else if (32'(r_ferns_raw) > MAX_FERN_BITS) w_ferns = FW'(MAX_FERN_BITS);
        else w_ferns = FW'(r_ferns_raw);
        if (r_lms_raw == 5'd0) w_lms = LW'(1);
        else if (32'(r_lms_raw) > MAX_LANDMARKS) w_lms = LW'(MAX_LANDMARKS);
        else w_lms = LW'(r_lms_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_raw  <= 9'd256;
            r_rows_raw  <= 9'd256;
            r_ferns_raw <= 3'd5;
            r_lms_raw   <= 5'd29;
            r_rot[0]    <= Q_ONE;
            r_rot[1]    <= '0;
            r_rot[2]    <= '0;
            r_rot[3]    <= Q_ONE;
            r_scale     <= Q_ONE;
            r_box[0]    <= '0;
            r_box[1]    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLS:      r_cols_raw  <= i_cfg_data;
                    CFG_ROWS:      r_rows_raw  <= i_cfg_data;
                    CFG_FERNS:     r_ferns_raw <= i_cfg_data[2:0];
                    CFG_LANDMARKS: r_lms_raw   <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.load && r_op == OP_SET_XFORM) begin
                r_rot[0] <= r_a;
                r_rot[1] <= r_b;
                r_rot[2] <= r_c;
                r_rot[3] <= r_d;
                r_scale  <= r_aux;
                r_box[0] <= r_bw;
                r_box[1] <= r_bh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_slot <= i_slot;
            r_a    <= i_coord_a;
            r_b    <= i_coord_b;
            r_c    <= i_coord_c;
            r_d    <= i_coord_d;
            r_aux  <= i_aux_value;
            r_na   <= i_near_a;
            r_nb   <= i_near_b;
            r_bw   <= i_box_width;
            r_bh   <= i_box_height;
        end
        if (i_cmd.load && r_op == OP_LOAD_LANDMARK && 32'(r_slot) < MAX_LANDMARKS) begin
            r_lx[LIW'(r_slot)] <= r_a;
            r_ly[LIW'(r_slot)] <= r_b;
        end
        if (i_cmd.load && r_op == OP_LOAD_FEATURE && 32'(r_slot) < MAX_FERN_BITS) begin
            r_o1x[FIW'(r_slot)] <= r_a;
            r_o1y[FIW'(r_slot)] <= r_b;
            r_o2x[FIW'(r_slot)] <= r_c;
            r_o2y[FIW'(r_slot)] <= r_d;
            r_thr[FIW'(r_slot)] <= r_aux;
            r_an1[FIW'(r_slot)] <= r_na;
            r_an2[FIW'(r_slot)] <= r_nb;
        end
    end

    // projection sequencer: per fern, point 0 then point 1; each point runs
    // stages 0..6, x and y lanes in parallel
    logic [FIW-1:0] r_fern;
    logic           r_pt;
    logic [2:0]     r_stg;
    logic [MAX_FERN_BITS-1:0] r_bin;
    logic           r_done;
    logic signed [63:0] r_mx0, r_mx1, r_my0, r_my1;
    logic signed [31:0] r_dx, r_dy, r_sx, r_sy, r_tx, r_ty;
    logic [CW-1:0]  r_px;
    logic [RW-1:0]  r_py;
    logic [7:0]     r_i1;

    logic signed [31:0] w_ox, w_oy, w_ax, w_ay;
    logic [4:0]         w_anc;
    logic [LIW-1:0]     w_ai;
    logic [PAW-1:0]     w_paddr;
    logic [7:0]         w_pix;

    always_comb begin
        w_ox  = r_pt ? r_o2x[r_fern] : r_o1x[r_fern];
        w_oy  = r_pt ? r_o2y[r_fern] : r_o1y[r_fern];
        w_anc = r_pt ? r_an2[r_fern] : r_an1[r_fern];
        if (32'(w_anc) >= MAX_LANDMARKS) w_ai = LIW'(MAX_LANDMARKS - 1);
        else w_ai = LIW'(w_anc);
        w_ax = r_lx[w_ai];
        w_ay = r_ly[w_ai];
    end

    function automatic logic [15:0] clamp_pix(input logic signed [31:0] t,
                                              input logic signed [31:0] anc,
                                              input logic [12:0] dim);
        logic signed [33:0] p, hi;
        p  = 34'(t) + 34'(anc);
        hi = $signed({1'b0, 33'(dim - 13'd1)}) <<< 16;
        if (p < 0) p = '0;
        if (p > hi) p = hi;
        return p[31:16];
    endfunction

    logic [15:0] w_cx, w_cy;
    assign w_cx = clamp_pix(r_tx, w_ax, 13'(w_cols));
    assign w_cy = clamp_pix(r_ty, w_ay, 13'(w_rows));

    logic [PAW+CW-1:0] w_lin;
    assign w_lin   = (PAW+CW)'(r_py) * (PAW+CW)'(w_cols) + (PAW+CW)'(r_px);
    assign w_paddr = w_lin[PAW-1:0];

    logic signed [8:0]  w_diff;
    logic signed [47:0] w_lhs;
    assign w_diff = $signed({1'b0, r_i1}) - $signed({1'b0, w_pix});
    assign w_lhs  = 48'(w_diff) <<< 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg  <= '0;
            r_done <= 1'b0;
        end else if (i_cmd.prj_start) begin
            r_fern <= '0;
            r_pt   <= 1'b0;
            r_stg  <= '0;
            r_bin  <= '0;
            r_done <= 1'b0;
        end else if (i_cmd.prj_step && !r_done) begin
            r_stg <= (r_stg == 3'd6) ? 3'd0 : r_stg + 3'd1;
            case (r_stg)
                3'd0: begin
                    r_mx0 <= 64'(r_rot[0]) * 64'(w_ox);
                    r_mx1 <= 64'(r_rot[1]) * 64'(w_oy);
                    r_my0 <= 64'(r_rot[2]) * 64'(w_ox);
                    r_my1 <= 64'(r_rot[3]) * 64'(w_oy);
                end
                3'd1: begin
                    r_dx <= sat32((r_mx0 >>> 16) + (r_mx1 >>> 16));
                    r_dy <= sat32((r_my0 >>> 16) + (r_my1 >>> 16));
                end
                3'd2: begin
                    r_sx <= sat32((64'(r_dx) * 64'(r_scale)) >>> 16);
                    r_sy <= sat32((64'(r_dy) * 64'(r_scale)) >>> 16);
                end
                3'd3: begin
                    r_tx <= sat32((64'(r_sx) * $signed({48'd0, r_box[0]})) >>> 1);
                    r_ty <= sat32((64'(r_sy) * $signed({48'd0, r_box[1]})) >>> 1);
                end
                3'd4: begin
                    r_px <= CW'(w_cx);
                    r_py <= RW'(w_cy);
                end
                3'd5: ; // pixel address presented to the memory
                default: begin
                    if (!r_pt) begin
                        r_i1 <= w_pix;
                        r_pt <= 1'b1;
                    end else begin
                        r_pt <= 1'b0;
                        if (w_lhs >= 48'(r_thr[r_fern])) r_bin[r_fern] <= 1'b1;
                        if (FW'(r_fern) == w_ferns - FW'(1)) r_done <= 1'b1;
                        else r_fern <= r_fern + FIW'(1);
                    end
                end
            endcase
        end
    end

    fsrl_ram #(.WIDTH(8), .DEPTH(PIX_DEPTH)) u_pix (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load && r_op == OP_LOAD_PIXEL && 32'(r_slot) < PIX_DEPTH),
        .i_waddr(PAW'(r_slot)),
        .i_wdata(r_aux[7:0]),
        .i_raddr(w_paddr),
        .o_rdata(w_pix)
    );

    // emission
    logic [LIW-1:0] r_k;
    logic [BAW-1:0] r_baddr;
    logic [63:0]    w_bin_rd;
    logic [BAW+LW-1:0] w_bbase;

    assign w_bbase = (BAW+LW)'(r_bin) * (BAW+LW)'(w_lms);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_k     <= '0;
            r_baddr <= w_bbase[BAW-1:0];
        end else if (i_cmd.emit_next) begin
            r_k     <= r_k + LIW'(1);
            r_baddr <= r_baddr + BAW'(1);
        end
    end

    fsrl_ram #(.WIDTH(64), .DEPTH(BIN_DEPTH)) u_bin (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load && r_op == OP_LOAD_BIN && 32'(r_slot) < BIN_DEPTH),
        .i_waddr(BAW'(r_slot)),
        .i_wdata({r_b, r_a}),
        .i_raddr(r_baddr),
        .o_rdata(w_bin_rd)
    );

    assign o_status.prj_done  = r_done;
    assign o_status.emit_last = (LW'(r_k) == w_lms - LW'(1));
    assign o_landmark_index   = 5'(r_k);
    assign o_delta_x          = w_bin_rd[31:0];
    assign o_delta_y          = w_bin_rd[63:32];
    assign o_bin_index        = 5'(r_bin);
    assign o_last             = o_status.emit_last;
endmodule

// File: rtl/core/fern_shape_regression_lookup.sv
// Loads: each item is accepted, then written to its store; no result.
// Predict: each projected point runs the projection stages, two points per fern test;
// the first result is valid once all fern tests finish and the bin read and wait are done,
// and each further landmark result follows the previous transfer (read, wait, transfer).
// One item at a time; pixel lookups share one memory read port.
// Reset (i_rst_n low, synchronous) restores the identity transform and default registers.
module fern_shape_regression_lookup import fsrl_pkg::*; #(
    parameter int MAX_FERN_BITS = 5,
    parameter int MAX_LANDMARKS = 29,
    parameter int IMAGE_WIDTH   = 256,
    parameter int IMAGE_HEIGHT  = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[2:0]
    input  logic [2:0]   s_axis_tuser,
    // slot[15:0] coord_a[47:16] coord_b[79:48] coord_c[111:80] coord_d[143:112]
    // aux_value[175:144] near_a[180:176] near_b[185:181] box_width[201:186]
    // box_height[217:202], zero fill to 224
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // landmark_index[4:0] delta_x[36:5] delta_y[68:37] bin_index[73:69], zero fill
    output logic [79:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [8:0]   i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;
    t_op     w_op;
    logic [4:0]         w_li, w_bi;
    logic signed [31:0] w_dx, w_dy;

    assign w_op = t_op'(s_axis_tuser);

    fsrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (w_op),
        .i_out_ready(m_axis_tready),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    fsrl_dpath #(
        .MAX_FERN_BITS(MAX_FERN_BITS),
        .MAX_LANDMARKS(MAX_LANDMARKS),
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_op            (w_op),
        .i_slot          (s_axis_tdata[15:0]),
        .i_coord_a       (s_axis_tdata[47:16]),
        .i_coord_b       (s_axis_tdata[79:48]),
        .i_coord_c       (s_axis_tdata[111:80]),
        .i_coord_d       (s_axis_tdata[143:112]),
        .i_aux_value     (s_axis_tdata[175:144]),
        .i_near_a        (s_axis_tdata[180:176]),
        .i_near_b        (s_axis_tdata[185:181]),
        .i_box_width     (s_axis_tdata[201:186]),
        .i_box_height    (s_axis_tdata[217:202]),
        .o_status        (w_status),
        .o_landmark_index(w_li),
        .o_delta_x       (w_dx),
        .o_delta_y       (w_dy),
        .o_bin_index     (w_bi),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_bi, w_dy, w_dx, w_li};
endmodule

// File: rtl/core/fsrl_checker.sv
module fsrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // no input taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    // after a non-last transfer the index advances by one
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> ##2
        (m_axis_tdata[4:0] == $past(m_axis_tdata[4:0], 3) + 5'd1))
        else $error("landmark index skipped");

    // after the last transfer the block takes input again
    a_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not idle after last result");
endmodule

bind fern_shape_regression_lookup fsrl_checker u_fsrl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
